@@ rtl/core/sit_pkg.sv @@
package sit_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned AddrW = 64;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } sit_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_HIT,
    S_DONE
  } sit_state_t;

  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] start_addr;
    logic [AddrW-1:0] end_addr;
  } sit_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] found_start;
    logic [AddrW-1:0] found_end;
  } sit_rsp_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             hit_en;
    logic             commit;
    logic [AddrW-1:0] addr_s;
    logic [AddrW-1:0] addr_e;
  } sit_ctrl_t;

  // per-cell match report, data is zero unless the flag is set
  typedef struct packed {
    logic             prev_hit;
    logic             next_hit;
    logic [AddrW-1:0] prev_start;
    logic [AddrW-1:0] prev_end;
    logic [AddrW-1:0] next_start;
    logic [AddrW-1:0] next_end;
  } sit_hit_t;

endpackage

@@ rtl/core/sit_cell.sv @@
module sit_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sit_pkg::sit_ctrl_t           ctrl,
  input  logic                         left_valid,
  input  logic                         left_lt,
  input  logic [sit_pkg::AddrW-1:0]    left_start,
  input  logic [sit_pkg::AddrW-1:0]    left_end,
  input  logic                         right_lt,
  output logic [sit_pkg::AddrW-1:0]    cell_start,
  output logic [sit_pkg::AddrW-1:0]    cell_end,
  output logic                         cell_valid,
  output logic                         cell_lt,
  output sit_pkg::sit_hit_t            hit
);
  import sit_pkg::*;

  logic [AddrW-1:0] start_r, end_r;
  logic [AddrW-1:0] start_nxt, end_nxt;
  logic             valid_r, valid_nxt;
  logic             lt_r, above_r, below_r;
  logic             at_pos;
  sit_hit_t         hit_r, hit_nxt;

  // this cell is the first one whose start is not below the request start
  assign at_pos = !lt_r && left_lt;

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    valid_nxt = valid_r;
    if (!lt_r) begin
      if (at_pos) begin
        start_nxt = ctrl.addr_s;
        end_nxt   = ctrl.addr_e;
        valid_nxt = 1'b1;
      end else begin
        start_nxt = left_start;
        end_nxt   = left_end;
        valid_nxt = left_valid;
      end
    end
  end

  always_comb begin
    hit_nxt          = '0;
    hit_nxt.prev_hit = lt_r && !right_lt && above_r;
    hit_nxt.next_hit = valid_r && at_pos && below_r;
    if (hit_nxt.prev_hit) begin
      hit_nxt.prev_start = start_r;
      hit_nxt.prev_end   = end_r;
    end
    if (hit_nxt.next_hit) begin
      hit_nxt.next_start = start_r;
      hit_nxt.next_end   = end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
    if (ctrl.cmp_en) begin
      lt_r    <= valid_r && (start_r < ctrl.addr_s);
      above_r <= end_r > ctrl.addr_s;
      below_r <= start_r < ctrl.addr_e;
    end
    if (ctrl.hit_en) begin
      hit_r <= hit_nxt;
    end
  end

  assign cell_start = start_r;
  assign cell_end   = end_r;
  assign cell_valid = valid_r;
  assign cell_lt    = lt_r;
  assign hit        = hit_r;

endmodule

@@ rtl/core/sit_merge.sv @@
module sit_merge #(
  parameter int unsigned TABLE_DEPTH = sit_pkg::TableDepthDefault
) (
  input  sit_pkg::sit_hit_t hits [TABLE_DEPTH],
  input  logic              cmd,
  input  logic              full,
  output sit_pkg::sit_rsp_t rsp,
  output logic              insert_ok
);
  import sit_pkg::*;

  sit_hit_t any;

  // at most one cell raises each flag, so an or over the row selects it
  always_comb begin
    any = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any = any | hits[i];
    end
  end

  always_comb begin
    rsp       = '0;
    insert_ok = 1'b0;
    if (cmd == CMD_LOOKUP) begin
      if (any.prev_hit) begin
        rsp.status      = ST_OK;
        rsp.found_start = any.prev_start;
        rsp.found_end   = any.prev_end;
      end else if (any.next_hit) begin
        rsp.status      = ST_OK;
        rsp.found_start = any.next_start;
        rsp.found_end   = any.next_end;
      end else begin
        rsp.status = ST_MISS;
      end
    end else if (any.prev_hit || any.next_hit) begin
      rsp.status = ST_OVERLAP;
    end else if (full) begin
      rsp.status = ST_FULL;
    end else begin
      rsp.status = ST_OK;
      insert_ok  = 1'b1;
    end
  end

endmodule

@@ rtl/core/sorted_interval_table_unit.sv @@
// Sorted interval table: keeps non-overlapping [start, end) intervals ordered
// by start, one cell per entry, and answers lookup and insert requests.
// Input channel in_valid/in_stall/in_data carries cmd, start_addr, end_addr;
// result channel out_valid/out_stall/out_data carries status and the hit bounds.
// Every request gives exactly one result.
// Steps: after the input transfer the request runs through S_CMP, S_HIT and
// S_DONE. S_CMP runs the compares in every cell, S_HIT marks the neighbor
// cells, S_DONE merges the row into the output register and, for an accepted
// insert, shifts all later cells up by one in the same cycle.
// Requests do not overlap: the next one is taken only in S_IDLE, after the
// three steps above.
// in_stall is high while a request is in flight; the result sits in an output
// register, so a new request may be taken while the previous result waits.
// If the receiver stalls, the finished request holds in the merge step until
// the output register frees up; no result is lost.
// Reset empties the table (all cell valid bits and the entry count clear) and
// drops any request or result in flight.
module sorted_interval_table_unit #(
  parameter int unsigned TABLE_DEPTH = sit_pkg::TableDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sit_pkg::sit_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sit_pkg::sit_rsp_t out_data
);
  import sit_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  sit_state_t       state_r, state_nxt;
  sit_req_t         req_r;
  sit_ctrl_t        ctrl;
  sit_rsp_t         rsp, out_data_r;
  logic             out_valid_r;
  logic [CntW-1:0]  count_r;
  logic             full, insert_ok, out_load, commit;

  logic [AddrW-1:0] c_start [TABLE_DEPTH];
  logic [AddrW-1:0] c_end   [TABLE_DEPTH];
  logic             c_valid [TABLE_DEPTH];
  logic             c_lt    [TABLE_DEPTH];
  sit_hit_t         c_hit   [TABLE_DEPTH];

  assign full = (count_r == CntW'(TABLE_DEPTH));

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic             l_valid, l_lt, r_lt;
    logic [AddrW-1:0] l_start, l_end;
    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_lt    = 1'b1;
      assign l_start = '0;
      assign l_end   = '0;
    end else begin : g_inner
      assign l_valid = c_valid[i-1];
      assign l_lt    = c_lt[i-1];
      assign l_start = c_start[i-1];
      assign l_end   = c_end[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_lt = 1'b0;
    end else begin : g_mid
      assign r_lt = c_lt[i+1];
    end

    sit_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_valid (l_valid),
      .left_lt    (l_lt),
      .left_start (l_start),
      .left_end   (l_end),
      .right_lt   (r_lt),
      .cell_start (c_start[i]),
      .cell_end   (c_end[i]),
      .cell_valid (c_valid[i]),
      .cell_lt    (c_lt[i]),
      .hit        (c_hit[i])
    );
  end

  sit_merge #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_merge (
    .hits      (c_hit),
    .cmd       (req_r.cmd),
    .full      (full),
    .rsp       (rsp),
    .insert_ok (insert_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    out_load    = 1'b0;
    commit      = 1'b0;
    ctrl        = '0;
    ctrl.addr_s = req_r.start_addr;
    ctrl.addr_e = req_r.end_addr;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = S_HIT;
      end
      S_HIT: begin
        ctrl.hit_en = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // wait here until the output register can take the result
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          commit    = (req_r.cmd == CMD_INSERT) && insert_ok;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    ctrl.commit = commit;
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        count_r <= count_r + CntW'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> count_r == $past(count_r) + CntW'(1))
    else $error("insert did not advance the entry count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && rsp.status == ST_FULL) |-> full && (req_r.cmd == CMD_INSERT))
    else $error("table full reported without a full table");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> state_r == S_IDLE && out_valid_r)
    else $error("result transfer did not return the sequencer to idle");

endmodule
